FILE: design/pwsbr_pkg.sv
`default_nettype none

package pwsbr_pkg;

  localparam int unsigned DATA_BITS  = 8;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned LIMIT_W    = 13;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(21);
  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(3);
  localparam logic [COUNT_W-1:0] LAST_BIT  = COUNT_W'(DATA_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LIMIT = 2'd0,
    REG_TICK_SHIFT  = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_STOP = 2'd2,
    PH_RSVD = 2'd3
  } phase_t;

  typedef struct packed {
    logic              arm_rising_next;
    logic              bit_valid;
    logic              decoded_bit;
    logic              byte_done;
    logic [BYTE_W-1:0] byte_value;
  } result_t;

endpackage

`default_nettype wire

FILE: design/pwsbr_bit_dec.sv
`default_nettype none

module pwsbr_bit_dec (
  input  wire logic [pwsbr_pkg::TIME_W-1:0]  capture_time,
  input  wire logic [pwsbr_pkg::TIME_W-1:0]  last_edge_time,
  input  wire logic [pwsbr_pkg::LIMIT_W-1:0] short_pulse_limit,
  input  wire logic [pwsbr_pkg::SHIFT_W-1:0] tick_shift,
  output logic                               bit_one
);

  logic [pwsbr_pkg::TIME_W-1:0] width;
  logic [pwsbr_pkg::TIME_W-1:0] scaled;

  always_comb begin
    width   = capture_time - last_edge_time;
    scaled  = width >> tick_shift;
    bit_one = scaled < {{(pwsbr_pkg::TIME_W - pwsbr_pkg::LIMIT_W){1'b0}}, short_pulse_limit};
  end

endmodule

`default_nettype wire

FILE: design/pwsbr_frame.sv
`default_nettype none

module pwsbr_frame (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire logic [pwsbr_pkg::TIME_W-1:0]     capture_time,
  input  wire logic                             bit_one,
  output logic      [pwsbr_pkg::TIME_W-1:0]     last_edge_time,
  output pwsbr_pkg::result_t                    result
);

  logic                              awaiting_r, awaiting_nxt;
  logic [pwsbr_pkg::TIME_W-1:0]      last_r, last_nxt;
  pwsbr_pkg::phase_t                 phase_r, phase_nxt;
  logic [pwsbr_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [pwsbr_pkg::BYTE_W-1:0]      shreg_r, shreg_nxt;
  logic                              done;

  assign last_edge_time = last_r;

  always_comb begin
    phase_nxt = phase_r;
    if (awaiting_r) begin
      unique case (phase_r)
        pwsbr_pkg::PH_DATA: begin
          if (count_r == pwsbr_pkg::LAST_BIT) phase_nxt = pwsbr_pkg::PH_STOP;
        end
        pwsbr_pkg::PH_STOP: phase_nxt = pwsbr_pkg::PH_IDLE;
        default: begin
          phase_nxt = bit_one ? pwsbr_pkg::PH_IDLE : pwsbr_pkg::PH_DATA;
        end
      endcase
    end
  end

  always_comb begin
    awaiting_nxt = ~awaiting_r;
    last_nxt     = awaiting_r ? last_r : capture_time;
    count_nxt    = count_r;
    shreg_nxt    = shreg_r;
    done         = 1'b0;
    if (awaiting_r) begin
      unique case (phase_r)
        pwsbr_pkg::PH_DATA: begin
          if (bit_one && !count_r[pwsbr_pkg::COUNT_W-1])
            shreg_nxt = shreg_r | (pwsbr_pkg::BYTE_W'(1) << count_r[2:0]);
          count_nxt = count_r + 1'b1;
        end
        pwsbr_pkg::PH_STOP: done = bit_one;
        default: begin
          if (!bit_one) begin
            count_nxt = '0;
            shreg_nxt = '0;
          end
        end
      endcase
    end
    result.arm_rising_next = awaiting_nxt;
    result.bit_valid       = awaiting_r;
    result.decoded_bit     = awaiting_r & bit_one;
    result.byte_done       = done;
    result.byte_value      = shreg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      last_r     <= '0;
      phase_r    <= pwsbr_pkg::PH_IDLE;
      count_r    <= '0;
      shreg_r    <= '0;
    end else if (accept) begin
      awaiting_r <= awaiting_nxt;
      last_r     <= last_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      shreg_r    <= shreg_nxt;
    end
  end

  a_edge_alternates: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> awaiting_r != $past(awaiting_r))
    else $error("capture edge did not alternate");

  a_done_needs_one: assert property (@(posedge clk) disable iff (!rst_n)
    result.byte_done |-> (result.bit_valid && result.decoded_bit && phase_r == pwsbr_pkg::PH_STOP))
    else $error("byte_done without a good stop");

  a_last_bit_to_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && awaiting_r && phase_r == pwsbr_pkg::PH_DATA && count_r == pwsbr_pkg::LAST_BIT)
    |=> phase_r == pwsbr_pkg::PH_STOP)
    else $error("data phase did not end after last bit");

  a_falling_holds_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !awaiting_r) |=> $stable(shreg_r) && $stable(phase_r))
    else $error("falling edge changed frame state");

endmodule

`default_nettype wire

FILE: design/pulse_width_serial_byte_receiver_core.sv
// Channel | Direction | Handshake           | Payload
// in_     | slave     | in_tvalid/in_tready   | tdata[15:0] capture_time
// out_    | master    | out_tvalid/out_tready | tdata bit fields, tuser bit_valid,
//         |           |                       | tlast byte_done
// cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One capture per cycle; its result appears in the output register the next cycle.
// Throughput is set by the single output register: in_tready drops only while a
// result is held and out_tready is low.
// Reset (rst_n low, synchronous) arms for a falling edge, idles the frame and
// loads short_pulse_limit 21 and tick_shift 3. cfg_ready is always high.
`default_nettype none

module pulse_width_serial_byte_receiver_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [15:0]                         in_tdata,   // [15:0] capture_time
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [15:0]                              out_tdata,  // [0] arm_rising_next,
                                                               // [1] decoded_bit,
                                                               // [9:2] byte_value, zero fill
  output logic                                     out_tuser,  // [0] bit_valid
  output logic                                     out_tlast,  // byte_done
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pwsbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pwsbr_pkg::LIMIT_W-1:0]       cfg_data
);

  logic [pwsbr_pkg::LIMIT_W-1:0] limit_r;
  logic [pwsbr_pkg::SHIFT_W-1:0] shift_r;
  logic [pwsbr_pkg::TIME_W-1:0]  last_edge_time;
  logic                          bit_one;
  logic                          accept;
  logic                          out_valid_r, out_valid_nxt;
  pwsbr_pkg::result_t            result;
  pwsbr_pkg::result_t            res_r;

  assign cfg_ready = 1'b1;
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= pwsbr_pkg::LIMIT_RST;
      shift_r <= pwsbr_pkg::SHIFT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pwsbr_pkg::REG_SHORT_LIMIT: limit_r <= cfg_data;
        pwsbr_pkg::REG_TICK_SHIFT:  shift_r <= cfg_data[pwsbr_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  pwsbr_bit_dec u_dec (
    .capture_time      (in_tdata),
    .last_edge_time    (last_edge_time),
    .short_pulse_limit (limit_r),
    .tick_shift        (shift_r),
    .bit_one           (bit_one)
  );

  pwsbr_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .capture_time   (in_tdata),
    .bit_one        (bit_one),
    .last_edge_time (last_edge_time),
    .result         (result)
  );

  assign out_valid_nxt = accept | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.byte_value, res_r.decoded_bit, res_r.arm_rising_next};
  assign out_tuser  = res_r.bit_valid;
  assign out_tlast  = res_r.byte_done;

endmodule

`default_nettype wire
